>>> rtl/mhkm_pkg.sv
package mhkm_pkg;

  localparam int RUN_W     = 5;
  localparam int KEY_IN_W  = 32;
  localparam int COUNT_O_W = 6;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_BUILD   = 2'd1,
    CMD_REPLACE = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_HOLD,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_DONE
  } state_t;

endpackage

>>> rtl/min_heap_kway_merge_selector_top.sv
// Binary min-heap of up to NUM_RUNS (key, run) entries for a k-way merge. Each
// command item returns one result item with the root entry, the entry count
// and an error flag. The heap lives in a two-read, one-write RAM; the entry
// being sifted is held in a register and children move up into the hole, so
// each heap level passes a read state (both children) and then a compare and
// write state. A replace or a remove walks L <= ceil(log2(NUM_RUNS)) levels;
// a build sifts down each of the n/2 inner nodes in turn. A new command item
// is taken while the previous result waits.
module min_heap_kway_merge_selector_top
  import mhkm_pkg::*;
#(
  parameter int NUM_RUNS  = 32,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // key[31:0], run[36:32], zero[39:37]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // top_key[31:0], top_run[36:32], entry_count[42:37],
                                 // is_empty[43], op_error[44], zero[47:45]
);

  localparam int AW = (NUM_RUNS > 1) ? $clog2(NUM_RUNS) : 1;
  localparam int CW = $clog2(NUM_RUNS + 1);
  localparam int LW = AW + 2;
  localparam int EW = KEY_WIDTH + RUN_W;

  state_t state, state_next;

  logic [CW-1:0]        count;
  logic [EW-1:0]        root;
  logic [EW-1:0]        held;
  logic [AW-1:0]        pos;
  logic [AW-1:0]        bidx;
  logic [AW-1:0]        faddr;
  logic                 err;
  logic                 building;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [EW-1:0]        wdata;
  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  logic [EW-1:0]        rd_a;
  logic [EW-1:0]        rd_b;

  logic                 accept;
  cmd_t                 cmd;
  logic [KEY_WIDTH-1:0] in_key;
  logic [RUN_W-1:0]     in_run;
  logic                 full;
  logic                 empty;
  logic [LW-1:0]        left;
  logic [LW-1:0]        right;
  logic [LW-1:0]        cnt_l;
  logic                 has_left;
  logic                 has_right;
  logic                 take_right;
  logic [EW-1:0]        pick;
  logic [AW-1:0]        pick_addr;
  logic                 go_down;
  logic                 more_build;
  logic                 out_load;

  assign accept     = s_tvalid && s_tready;
  assign cmd        = cmd_t'(s_tuser);
  assign in_key     = KEY_WIDTH'(s_tdata[KEY_IN_W-1:0]);
  assign in_run     = s_tdata[KEY_IN_W+RUN_W-1:KEY_IN_W];
  assign full       = (count == CW'(NUM_RUNS));
  assign empty      = (count == '0);
  assign left       = LW'({pos, 1'b1});
  assign right      = left + LW'(1);
  assign cnt_l      = LW'(count);
  assign has_left   = (left < cnt_l);
  assign has_right  = (right < cnt_l);
  assign take_right = has_right && (rd_a[EW-1:RUN_W] > rd_b[EW-1:RUN_W]);
  assign pick       = take_right ? rd_b : rd_a;
  assign pick_addr  = take_right ? right[AW-1:0] : left[AW-1:0];
  assign go_down    = (held[EW-1:RUN_W] > pick[EW-1:RUN_W]);
  assign more_build = building && (bidx != '0);

  mhkm_ram #(
    .DEPTH(NUM_RUNS),
    .AW   (AW),
    .DW   (EW)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_LOAD:    state_next = ST_DONE;
            CMD_BUILD:   state_next = (count > CW'(1)) ? ST_FETCH : ST_DONE;
            CMD_REPLACE: state_next = empty ? ST_DONE : ST_SIFT_RD;
            CMD_REMOVE:  state_next = empty ? ST_DONE : ST_FETCH;
          endcase
        end
      end
      ST_FETCH:    state_next = ST_HOLD;
      ST_HOLD:     state_next = ST_SIFT_RD;
      ST_SIFT_RD: begin
        if (has_left) begin
          state_next = ST_SIFT_CMP;
        end else begin
          state_next = more_build ? ST_FETCH : ST_DONE;
        end
      end
      ST_SIFT_CMP: begin
        if (go_down) begin
          state_next = ST_SIFT_RD;
        end else begin
          state_next = more_build ? ST_FETCH : ST_DONE;
        end
      end
      ST_DONE:     state_next = out_load ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    out_load = (state == ST_DONE) && (!m_tvalid || m_tready);
    we       = 1'b0;
    waddr    = pos;
    wdata    = held;
    raddr_a  = left[AW-1:0];
    raddr_b  = right[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept && (cmd == CMD_LOAD) && !full) begin
          we    = 1'b1;
          waddr = AW'(count);
          wdata = {in_key, in_run};
        end
      end
      ST_FETCH:    raddr_a = faddr;
      ST_SIFT_RD:  we = !has_left;
      ST_SIFT_CMP: begin
        we = 1'b1;
        if (go_down) begin
          wdata = pick;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      building <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        building <= (cmd == CMD_BUILD) && (count > CW'(1));
        if ((cmd == CMD_LOAD) && !full) begin
          count <= count + CW'(1);
        end
        if ((cmd == CMD_REMOVE) && !empty) begin
          count <= count - CW'(1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == '0)) begin
      root <= wdata;
    end
    if (accept) begin
      unique case (cmd)
        CMD_LOAD: begin
          err <= full;
        end
        CMD_BUILD: begin
          err   <= 1'b0;
          bidx  <= AW'((count >> 1) - CW'(1));
          faddr <= AW'((count >> 1) - CW'(1));
          pos   <= AW'((count >> 1) - CW'(1));
        end
        CMD_REPLACE: begin
          err  <= empty;
          held <= {in_key, root[RUN_W-1:0]};
          pos  <= '0;
        end
        CMD_REMOVE: begin
          err   <= empty;
          faddr <= AW'(count - CW'(1));
          pos   <= '0;
        end
      endcase
    end
    if (state == ST_HOLD) begin
      held <= rd_a;
    end
    if ((state == ST_SIFT_CMP) && go_down) begin
      pos <= pick_addr;
    end
    if (more_build && (((state == ST_SIFT_RD) && !has_left) ||
                       ((state == ST_SIFT_CMP) && !go_down))) begin
      bidx  <= bidx - AW'(1);
      faddr <= bidx - AW'(1);
      pos   <= bidx - AW'(1);
    end
    if (out_load) begin
      m_tdata <= {3'b000, err, empty, COUNT_O_W'(count),
                  empty ? {RUN_W{1'b0}} : root[RUN_W-1:0],
                  empty ? {KEY_IN_W{1'b0}} : KEY_IN_W'(root[EW-1:RUN_W])};
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(NUM_RUNS))
    else $error("entry count above capacity");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_REMOVE) && !empty) |=> (count == $past(count) - CW'(1)))
    else $error("remove did not drop one entry");

  a_full_err: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_LOAD) && full) |=> (err && (count == $past(count))))
    else $error("load into full heap not refused");

  a_sift_deeper: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SIFT_CMP) && go_down) |=> (pos > $past(pos)))
    else $error("sift step did not move down");
`endif

endmodule

>>> rtl/mhkm_ram.sv
module mhkm_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 37
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
